@@ sv/sha256_pkg.sv @@
// sha256_pkg: round constants, initial hash values, padding constants and round helpers
// no dependencies
`timescale 1ns / 1ps
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  // control from sequencer to round unit
  typedef struct packed {
    logic       load;   // load working vars from chaining value
    logic       step;   // run one round
    logic [5:0] rnd;    // round number
  } round_ctl_t;

  function automatic word_t ror(input word_t x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ sv/sha256_round.sv @@
// sha256_round: one compression round per cycle while step is set, plus message schedule window
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_round (
  input  logic                    clk,
  input  sha256_pkg::round_ctl_t  ctl,
  input  sha256_pkg::word_t       chain [8],
  input  logic [511:0]            block,
  output sha256_pkg::word_t       vars [8]
);
  import sha256_pkg::*;

  word_t w [16];
  word_t a_r [8];
  word_t wcur, wnew, s0, s1, t1, t2;

  assign wcur = (ctl.rnd < 6'd16) ? block[511 - 32*ctl.rnd[3:0] -: 32] : w[15];
  always_comb begin
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
  end

  // window: w[15] newest; when rnd>=16 it holds w[rnd-1], the word used by the previous round
  word_t wuse;
  assign wuse = (ctl.rnd < 6'd16) ? wcur : wnew;

  always_comb begin
    t1 = a_r[7] + (ror(a_r[4], 6) ^ ror(a_r[4], 11) ^ ror(a_r[4], 25))
       + ((a_r[4] & a_r[5]) ^ (~a_r[4] & a_r[6])) + ROUND_K[ctl.rnd] + wuse;
    t2 = (ror(a_r[0], 2) ^ ror(a_r[0], 13) ^ ror(a_r[0], 22))
       + ((a_r[0] & a_r[1]) ^ (a_r[0] & a_r[2]) ^ (a_r[1] & a_r[2]));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) a_r[i] <= chain[i];
    end else if (ctl.step) begin
      a_r[7] <= a_r[6]; a_r[6] <= a_r[5]; a_r[5] <= a_r[4];
      a_r[4] <= a_r[3] + t1;
      a_r[3] <= a_r[2]; a_r[2] <= a_r[1]; a_r[1] <= a_r[0];
      a_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wuse;
    end
  end

  assign vars = a_r;
endmodule

@@ sv/sha256_message_hash.sv @@
// sha256_message_hash: byte-serial sha-256 with padding and digest output
// depends on sha256_pkg, sha256_round
// last beat: one or two compressions, then four output beats
// throughput: one round per cycle through the shared round unit; not ready
// while a block compresses or the digest drains
// reset (rst, synchronous): initial hash values, fill and bit count cleared
`timescale 1ns / 1ps
module sha256_message_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // digest_part[63:0]
  output logic [1:0]  m_tuser,   // part_index[1:0]
  output logic        m_tlast    // final_part
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0, ST_LOAD = 3'd1, ST_RUN = 3'd2,
                         ST_ADD = 3'd3, ST_OUT = 3'd4;

  logic [2:0]  state;
  logic [511:0] block;      // byte 0 in the top bits
  logic [5:0]  fill;
  logic [63:0] bitcnt;
  word_t       chain [8];
  word_t       vars [8];
  logic [5:0]  rnd;
  logic        fin;         // compressing a padding block
  logic        second;      // a further padding block follows
  logic [1:0]  part;
  round_ctl_t  ctl;

  assign s_tready = (state == ST_IDLE);
  assign ctl.load = (state == ST_LOAD);
  assign ctl.step = (state == ST_RUN);
  assign ctl.rnd  = rnd;

  sha256_round u_round (.clk(clk), .ctl(ctl), .chain(chain), .block(block), .vars(vars));

  logic acc;
  assign acc = s_tvalid && s_tready;

  // padded block for the final item, given fill f and the byte just taken
  logic [5:0]  f_eff;
  logic [511:0] blk_in, pad_blk;
  logic [63:0] len_eff;
  always_comb begin
    blk_in = block;
    f_eff = fill;
    len_eff = bitcnt;
    if (s_tuser) begin
      blk_in[511 - 8*fill -: 8] = s_tdata;
      f_eff = fill + 6'd1;
      len_eff = bitcnt + 64'd8;
    end
    pad_blk = blk_in;
    for (int i = 0; i < 64; i++) begin
      if (i == f_eff) pad_blk[511 - 8*i -: 8] = PAD_BYTE;
      else if (i > f_eff) pad_blk[511 - 8*i -: 8] = 8'd0;
    end
    if (f_eff < LEN_START) pad_blk[63:0] = len_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      bitcnt <= '0;
      rnd <= '0;
      fin <= 1'b0;
      second <= 1'b0;
      part <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
    end else begin
      case (state)
        ST_IDLE: if (acc) begin
          if (s_tlast) begin
            // a block completing exactly at end is caught by the fill == 63 test, as f_eff wraps to 0
            bitcnt <= len_eff;
            second <= (f_eff >= LEN_START) || (s_tuser && fill == 6'd63);
            if (s_tuser && fill == 6'd63) begin
              block <= blk_in;
              fin <= 1'b0;
            end else begin
              block <= pad_blk;
              fin <= 1'b1;
            end
            state <= ST_LOAD;
          end else if (s_tuser) begin
            block <= blk_in;
            fill <= fill + 6'd1;
            bitcnt <= len_eff;
            if (fill == 6'd63) state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rnd <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[i];
          fill <= '0;
          if (second) begin
            second <= 1'b0;
            block <= {(fin ? 8'd0 : PAD_BYTE), 440'd0, bitcnt};
            fin <= 1'b1;
            state <= ST_LOAD;
          end else if (fin) begin
            part <= '0;
            state <= ST_OUT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: if (m_tready) begin
          part <= part + 2'd1;
          if (part == 2'd3) begin
            for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
            bitcnt <= '0;
            fin <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {chain[{part, 1'b0}], chain[{part, 1'b1}]};
  assign m_tuser  = part;
  assign m_tlast  = (part == 2'd3);

  // no input taken while busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("ready while busy");
  // digest beats only after a final compression
  a_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_ADD) else $error("stray digest");
  // a load is followed by the run state with round 0
  a_rnd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_RUN && rnd == 6'd0)) else $error("round start");
endmodule
